@@ hw/rtl/rsat_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the ack tracker.
// No dependencies; used by rsat_table and reliable_send_ack_tracker_top.
package rsat_pkg;

    localparam int SEQ_W     = 32;
    localparam int TIME_W    = 32;
    localparam int RETRY_W   = 8;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int PEND_W    = 6;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_RESULTS = 32;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);
    localparam int ACK_LIMIT   = 32;

    localparam logic [CMD_W-1:0] CMD_TRACK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACK      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LIST_DUE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_EXP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTX = 1'd1;

    localparam logic [CFG_W-1:0]   TIMEOUT_RST = 32'd200;
    localparam logic [RETRY_W-1:0] MAX_RTX_RST = 8'd5;
    localparam logic [RETRY_W-1:0] RETRY_SAT   = 8'hFF;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  sent;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    seq;
        logic [RETRY_W-1:0]  count;
        logic [PEND_W-1:0]   pending;
        logic [TIME_W-1:0]   sent;
        logic                present;
        logic                last;
    } result_t;

endpackage

@@ hw/rtl/reliable_send_ack_tracker_top.sv @@
`timescale 1ns / 1ps
// Ack tracker top: sequencer walking the entry table one entry at a time, S_READ then S_EVAL.
// A scan covers the N entries held at accept and stops early on a found entry or a full
// result list; an unused code skips the scan, and an output stall holds the final result.
// Throughput: one request at a time, next accepted in the cycle after the final result;
// list hits also wait on the output.
// Reset clears occupancy and control; registers return to 200 and 5. Uses rsat_pkg, rsat_table.
module reliable_send_ack_tracker_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int ACK_WINDOW  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rsat_pkg::CMD_W-1:0]         cmd,
    input  logic [rsat_pkg::SEQ_W-1:0]         seq_num,
    input  logic [rsat_pkg::SEQ_W-1:0]         ack_mask,
    input  logic [rsat_pkg::TIME_W-1:0]        now_ticks,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rsat_pkg::STATUS_W-1:0]      status,
    output logic [rsat_pkg::SEQ_W-1:0]         seq_out,
    output logic [rsat_pkg::RETRY_W-1:0]       count_out,
    output logic [rsat_pkg::PEND_W-1:0]        pending_count,
    output logic [rsat_pkg::TIME_W-1:0]        sent_time,
    output logic                               present,
    output logic                               last,
    input  logic                               cfg_we,
    input  logic [rsat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsat_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t                              state_reg;
    logic [rsat_pkg::CMD_W-1:0]          cmd_reg;
    logic [rsat_pkg::SEQ_W-1:0]          seq_reg;
    logic [rsat_pkg::SEQ_W-1:0]          mask_reg;
    logic [rsat_pkg::TIME_W-1:0]         now_reg;
    logic [CW-1:0]                       occ_reg;
    logic [CW-1:0]                       n_reg;
    logic [CW-1:0]                       i_reg;
    logic [CW-1:0]                       w_reg;
    logic [AW-1:0]                       idx_reg;
    logic                                found_reg;
    logic [rsat_pkg::K_W-1:0]            k_reg;
    rsat_pkg::entry_t                    held_reg;
    logic                                held_valid_reg;
    logic [rsat_pkg::CFG_W-1:0]          timeout_reg;
    logic [rsat_pkg::RETRY_W-1:0]        max_rtx_reg;
    rsat_pkg::result_t                   out_reg;
    logic                                out_valid_reg;

    rsat_pkg::entry_t                    ent;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    rsat_pkg::entry_t                    mem_wdata;
    logic                                mem_re;

    logic                                out_free;
    logic                                out_load;
    logic                                seq_hit;
    logic [rsat_pkg::SEQ_W-1:0]          behind;
    logic [rsat_pkg::SEQ_W-1:0]          back;
    logic [rsat_pkg::SEQ_W-1:0]          behind_m1;
    logic                                acked;
    logic [rsat_pkg::TIME_W-1:0]         elapsed;
    logic                                timed;
    logic                                below;
    logic                                list_hit;
    logic [rsat_pkg::RETRY_W-1:0]        new_retries;
    logic                                cmd_known;
    logic                                is_list;
    rsat_pkg::result_t                   held_res;
    rsat_pkg::result_t                   final_res;
    logic [CW-1:0]                       occ_final;

    rsat_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(i_reg[AW-1:0]),
        .rdata(ent)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign seq_out       = out_reg.seq;
    assign count_out     = out_reg.count;
    assign pending_count = out_reg.pending;
    assign sent_time     = out_reg.sent;
    assign present       = out_reg.present;
    assign last          = out_reg.last;

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_FINISH)
                      || ((state_reg == S_EVAL) && is_list && list_hit && held_valid_reg));

    // entry compare unit
    assign seq_hit   = (ent.seq == seq_reg);
    assign behind    = seq_reg - ent.seq;
    assign back      = ent.seq - seq_reg;
    assign behind_m1 = behind - 32'd1;
    assign acked     = seq_hit
                       || (back[31] && (behind <= 32'(ACK_WINDOW))
                           && (behind <= 32'(rsat_pkg::ACK_LIMIT))
                           && mask_reg[behind_m1[4:0]]);
    assign elapsed  = now_reg - ent.sent;
    assign timed    = (elapsed >= timeout_reg);
    assign below    = (ent.retries < max_rtx_reg);
    assign list_hit = timed && ((cmd_reg == rsat_pkg::CMD_LIST_DUE) ? below : !below);
    assign new_retries = (ent.retries == rsat_pkg::RETRY_SAT) ? rsat_pkg::RETRY_SAT
                                                               : ent.retries + 8'd1;
    assign cmd_known = (cmd == rsat_pkg::CMD_TRACK) || (cmd == rsat_pkg::CMD_ACK)
                       || (cmd == rsat_pkg::CMD_LIST_DUE) || (cmd == rsat_pkg::CMD_LIST_EXP)
                       || (cmd == rsat_pkg::CMD_MARK) || (cmd == rsat_pkg::CMD_QUERY);
    assign is_list = (cmd_reg == rsat_pkg::CMD_LIST_DUE) || (cmd_reg == rsat_pkg::CMD_LIST_EXP);

    always_comb
    begin
        held_res         = '0;
        held_res.status  = rsat_pkg::ST_OK;
        held_res.seq     = held_reg.seq;
        held_res.count   = held_reg.retries;
        held_res.pending = rsat_pkg::PEND_W'(occ_reg);
        held_res.sent    = held_reg.sent;
        held_res.present = 1'b1;
        held_res.last    = 1'b0;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = ent;
        mem_re    = (state_reg == S_READ) && (i_reg != n_reg);
        occ_final = occ_reg;
        final_res        = '0;
        final_res.status = rsat_pkg::ST_OK;
        final_res.last   = 1'b1;
        case (state_reg)
            S_EVAL:
            begin
                if ((cmd_reg == rsat_pkg::CMD_ACK) && !acked)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = w_reg[AW-1:0];
                end
            end
            S_FINISH:
            begin
                case (cmd_reg)
                    rsat_pkg::CMD_TRACK:
                    begin
                        if (found_reg)
                        begin
                            final_res.status = rsat_pkg::ST_DUP;
                        end
                        else if (n_reg >= CW'(TABLE_DEPTH))
                        begin
                            final_res.status = rsat_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we            = out_free;
                            mem_waddr         = n_reg[AW-1:0];
                            mem_wdata.seq     = seq_reg;
                            mem_wdata.sent    = now_reg;
                            mem_wdata.retries = '0;
                            occ_final         = n_reg + CW'(1);
                        end
                    end
                    rsat_pkg::CMD_ACK:
                    begin
                        occ_final       = w_reg;
                        final_res.count = rsat_pkg::RETRY_W'(n_reg - w_reg);
                    end
                    rsat_pkg::CMD_LIST_DUE, rsat_pkg::CMD_LIST_EXP:
                    begin
                        if (held_valid_reg)
                        begin
                            final_res      = held_res;
                            final_res.last = 1'b1;
                        end
                    end
                    rsat_pkg::CMD_MARK:
                    begin
                        if (found_reg)
                        begin
                            mem_we            = out_free;
                            mem_waddr         = idx_reg;
                            mem_wdata.sent    = now_reg;
                            mem_wdata.retries = new_retries;
                            final_res.seq     = seq_reg;
                            final_res.count   = new_retries;
                            final_res.sent    = now_reg;
                            final_res.present = 1'b1;
                        end
                        else
                        begin
                            final_res.status = rsat_pkg::ST_MISSING;
                        end
                    end
                    rsat_pkg::CMD_QUERY:
                    begin
                        if (found_reg)
                        begin
                            final_res.seq     = seq_reg;
                            final_res.count   = ent.retries;
                            final_res.sent    = ent.sent;
                            final_res.present = 1'b1;
                        end
                        else
                        begin
                            final_res.status = rsat_pkg::ST_MISSING;
                        end
                    end
                    default:
                    begin
                        final_res.status = rsat_pkg::ST_OK;
                    end
                endcase
                final_res.pending = rsat_pkg::PEND_W'(occ_final);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            seq_reg        <= '0;
            mask_reg       <= '0;
            now_reg        <= '0;
            occ_reg        <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            k_reg          <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            timeout_reg    <= rsat_pkg::TIMEOUT_RST;
            max_rtx_reg    <= rsat_pkg::MAX_RTX_RST;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rsat_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                    rsat_pkg::CFG_MAX_RTX: max_rtx_reg <= cfg_data[rsat_pkg::RETRY_W-1:0];
                    default:               timeout_reg <= timeout_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg        <= cmd;
                        seq_reg        <= seq_num;
                        mask_reg       <= ack_mask;
                        now_reg        <= now_ticks;
                        n_reg          <= occ_reg;
                        i_reg          <= '0;
                        w_reg          <= '0;
                        k_reg          <= '0;
                        found_reg      <= 1'b0;
                        held_valid_reg <= 1'b0;
                        state_reg      <= cmd_known ? S_READ : S_FINISH;
                    end
                end
                S_READ:
                begin
                    state_reg <= (i_reg == n_reg) ? S_FINISH : S_EVAL;
                end
                S_EVAL:
                begin
                    if (cmd_reg == rsat_pkg::CMD_ACK)
                    begin
                        if (!acked)
                        begin
                            w_reg <= w_reg + CW'(1);
                        end
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_READ;
                    end
                    else if (is_list)
                    begin
                        if (!list_hit)
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                        else if (!held_valid_reg)
                        begin
                            held_reg       <= ent;
                            held_valid_reg <= 1'b1;
                            k_reg          <= rsat_pkg::K_W'(1);
                            i_reg          <= i_reg + CW'(1);
                            state_reg      <= (rsat_pkg::MAX_RESULTS == 1) ? S_FINISH : S_READ;
                        end
                        else if (out_free)
                        begin
                            out_reg       <= held_res;
                            held_reg      <= ent;
                            k_reg         <= k_reg + rsat_pkg::K_W'(1);
                            i_reg         <= i_reg + CW'(1);
                            state_reg     <= (k_reg + rsat_pkg::K_W'(1)
                                              == rsat_pkg::K_W'(rsat_pkg::MAX_RESULTS))
                                             ? S_FINISH : S_READ;
                        end
                    end
                    else
                    begin
                        if (seq_hit)
                        begin
                            found_reg <= 1'b1;
                            idx_reg   <= i_reg[AW-1:0];
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_reg       <= final_res;
                        occ_reg       <= occ_final;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/rsat_table.sv @@
`timescale 1ns / 1ps
// Entry table memory: one write port, one registered read port.
// Depends on rsat_pkg for entry_t.
module rsat_table #(
    parameter int DEPTH = 32
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  rsat_pkg::entry_t        wdata,
    input  logic                    re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output rsat_pkg::entry_t        rdata
);

    rsat_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ tb/sv/reliable_send_ack_tracker_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for reliable_send_ack_tracker_top: a shadow of the ack table
// predicts every result; directed requests, then randomized phases under several settings.
// Depends on rsat_pkg and the tracker RTL.
module reliable_send_ack_tracker_top_tb;

    import rsat_pkg::*;

    localparam int DEPTH       = 32;
    localparam int ACK_WIN     = 32;
    localparam int PHASE_ITEMS = 45;
    localparam int IDLE_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT = 1_500_000;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    class retx_shadow;
        logic [SEQ_W-1:0]   seq_tab[DEPTH];
        logic [TIME_W-1:0]  sent_tab[DEPTH];
        logic [RETRY_W-1:0] retry_tab[DEPTH];
        int                 held;
        logic [CFG_W-1:0]   timeout;
        logic [RETRY_W-1:0] retry_limit;
        result_t            awaited_results[$];
        int                 errors;
        int                 requests;
        int                 results;

        function new();
            held        = 0;
            timeout     = TIMEOUT_RST;
            retry_limit = MAX_RTX_RST;
            errors      = 0;
            requests    = 0;
            results     = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] value);
            if (idx == CFG_TIMEOUT)
                timeout = value;
            else
                retry_limit = value[RETRY_W-1:0];
        endfunction

        function int find(input logic [SEQ_W-1:0] s);
            for (int i = 0; i < held; i++)
                if (seq_tab[i] == s)
                    return i;
            return -1;
        endfunction

        // older than the ack by 1..ACK_WIN and named in the mask, or equal to it
        function bit covered_by_ack(input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] ack,
                                    input logic [SEQ_W-1:0] mask);
            logic [SEQ_W-1:0] behind;
            logic [SEQ_W-1:0] ahead;
            behind = ack - s;
            ahead  = s - ack;
            if (s == ack)
                return 1'b1;
            if (!ahead[SEQ_W-1])
                return 1'b0;
            if (behind == 0 || behind > ACK_WIN)
                return 1'b0;
            return mask[behind-1];
        endfunction

        function void owe(input logic [STATUS_W-1:0] st, input logic [SEQ_W-1:0] s,
                          input logic [RETRY_W-1:0] cnt, input logic [TIME_W-1:0] t,
                          input logic pres, input logic fin);
            result_t r;
            r.status  = st;
            r.seq     = s;
            r.count   = cnt;
            r.pending = PEND_W'(held);
            r.sent    = t;
            r.present = pres;
            r.last    = fin;
            awaited_results = {awaited_results, r};
        endfunction

        function void note_request(input logic [CMD_W-1:0] op, input logic [SEQ_W-1:0] s,
                                   input logic [SEQ_W-1:0] mask, input logic [TIME_W-1:0] t);
            int                at;
            int                kept;
            int                hits[$];
            logic [TIME_W-1:0] age;
            bit                below;
            requests++;
            case (op)
                CMD_TRACK:
                begin
                    if (find(s) >= 0)
                        owe(ST_DUP, '0, '0, '0, 1'b0, 1'b1);
                    else if (held >= DEPTH)
                        owe(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        seq_tab[held]   = s;
                        sent_tab[held]  = t;
                        retry_tab[held] = '0;
                        held++;
                        owe(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                    end
                end
                CMD_ACK:
                begin
                    kept = 0;
                    for (int i = 0; i < held; i++)
                    begin
                        if (!covered_by_ack(seq_tab[i], s, mask))
                        begin
                            seq_tab[kept]   = seq_tab[i];
                            sent_tab[kept]  = sent_tab[i];
                            retry_tab[kept] = retry_tab[i];
                            kept++;
                        end
                    end
                    at   = held - kept;
                    held = kept;
                    owe(ST_OK, '0, RETRY_W'(at), '0, 1'b0, 1'b1);
                end
                CMD_LIST_DUE, CMD_LIST_EXP:
                begin
                    for (int i = 0; i < held && hits.size() < MAX_RESULTS; i++)
                    begin
                        age   = t - sent_tab[i];
                        below = retry_tab[i] < retry_limit;
                        if (age >= timeout && ((op == CMD_LIST_DUE) == below))
                            hits = {hits, i};
                    end
                    if (hits.size() == 0)
                        owe(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                    foreach (hits[j])
                        owe(ST_OK, seq_tab[hits[j]], retry_tab[hits[j]], sent_tab[hits[j]],
                            1'b1, j == hits.size() - 1);
                end
                CMD_MARK:
                begin
                    at = find(s);
                    if (at < 0)
                        owe(ST_MISSING, '0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        if (retry_tab[at] != RETRY_SAT)
                            retry_tab[at]++;
                        sent_tab[at] = t;
                        owe(ST_OK, s, retry_tab[at], t, 1'b1, 1'b1);
                    end
                end
                CMD_QUERY:
                begin
                    at = find(s);
                    if (at < 0)
                        owe(ST_MISSING, '0, '0, '0, 1'b0, 1'b1);
                    else
                        owe(ST_OK, s, retry_tab[at], sent_tab[at], 1'b1, 1'b1);
                end
                default:
                    owe(ST_OK, '0, '0, '0, 1'b0, 1'b1);
            endcase
        endfunction

        function void match_field(input string field, input logic [31:0] want,
                                  input logic [31:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(input result_t seen);
            result_t want;
            results++;
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d seq_out 0x%0h",
                       seen.status, seen.seq);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            match_field("status", 32'(want.status), 32'(seen.status));
            match_field("seq_out", want.seq, seen.seq);
            match_field("count_out", 32'(want.count), 32'(seen.count));
            match_field("pending_count", 32'(want.pending), 32'(seen.pending));
            match_field("sent_time", want.sent, seen.sent);
            match_field("present", 32'(want.present), 32'(seen.present));
            match_field("last", 32'(want.last), 32'(seen.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [SEQ_W-1:0]     seq_num;
    logic [SEQ_W-1:0]     ack_mask;
    logic [TIME_W-1:0]    now_ticks;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [SEQ_W-1:0]     seq_out;
    logic [RETRY_W-1:0]   count_out;
    logic [PEND_W-1:0]    pending_count;
    logic [TIME_W-1:0]    sent_time;
    logic                 present;
    logic                 last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    retx_shadow           sb;
    bit                   calm;
    int                   hold_request;
    int                   register_sets;
    int                   cycle_count;
    logic [SEQ_W-1:0]     seq_base;
    logic [TIME_W-1:0]    clock_now;

    reliable_send_ack_tracker_top #(
        .TABLE_DEPTH (DEPTH),
        .ACK_WINDOW  (ACK_WIN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .seq_num       (seq_num),
        .ack_mask      (ack_mask),
        .now_ticks     (now_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .seq_out       (seq_out),
        .count_out     (count_out),
        .pending_count (pending_count),
        .sent_time     (sent_time),
        .present       (present),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: stall count drawn per accepted result, or a long hold on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (out_valid && !out_stall)
                stall_left = calm ? 0 : $urandom_range(0, 16);
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (out_valid && !out_stall)
                sb.check_result(result_t'{status, seq_out, count_out, pending_count,
                                          sent_time, present, last});
            if (in_valid && !in_stall)
                sb.note_request(cmd, seq_num, ack_mask, now_ticks);
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] op, input logic [SEQ_W-1:0] s,
                                input logic [SEQ_W-1:0] mask, input logic [TIME_W-1:0] t);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        seq_num   <= s;
        ack_mask  <= mask;
        now_ticks <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    // mostly sequences near seq_base so acks, dups and a full table happen
    task automatic random_request(input int track_pct);
        int                roll;
        int                pick;
        logic [CMD_W-1:0]  op;
        logic [SEQ_W-1:0]  s;
        logic [SEQ_W-1:0]  mask;
        logic [TIME_W-1:0] t;
        roll      = $urandom_range(0, track_pct + 63);
        clock_now = clock_now + $urandom_range(0, 40);
        s         = seq_base + $urandom_range(0, 40);
        mask      = $urandom;
        t         = clock_now;
        pick      = (sb.held > 0) ? $urandom_range(0, sb.held - 1) : 0;
        if (roll < track_pct)
            op = CMD_TRACK;
        else if (roll < track_pct + 15)
        begin
            op = CMD_ACK;
            case ($urandom_range(0, 3))
                0: mask = '0;
                1: mask = '1;
                2: mask = 32'd1 << $urandom_range(0, 31);
                default: ;
            endcase
        end
        else if (roll < track_pct + 35)
        begin
            op = ($urandom_range(0, 1) != 0) ? CMD_LIST_DUE : CMD_LIST_EXP;
            // land right on the timeout edge of some entry
            if (sb.held > 0 && $urandom_range(0, 1) != 0)
                t = sb.sent_tab[pick] + sb.timeout - $urandom_range(0, 1);
        end
        else if (roll < track_pct + 55)
        begin
            op = ($urandom_range(0, 1) != 0) ? CMD_MARK : CMD_QUERY;
            if (sb.held > 0 && $urandom_range(0, 3) != 0)
                s = sb.seq_tab[pick];
        end
        else if (roll < track_pct + 58)
            op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        else
        begin
            op   = CMD_W'($urandom_range(0, 7));
            s    = $urandom;
            mask = $urandom;
            t    = $urandom;
        end
        send_request(op, s, mask, t);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] tmo, input logic [RETRY_W-1:0] limit,
                             input logic [SEQ_W-1:0] base, input int track_pct,
                             input int hold);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MAX_RTX, CFG_W'(limit));
        register_sets++;
        seq_base     = base;
        hold_request = hold;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            random_request(track_pct);
        end
        wait_idle();
    endtask

    initial
    begin
        sb            = new();
        calm          = 1'b0;
        hold_request  = 0;
        register_sets = 1;
        seq_base      = '0;
        clock_now     = 32'hFFFF_E000;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_TRACK;
        seq_num   <= '0;
        ack_mask  <= '0;
        now_ticks <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused codes
        send_request(CMD_QUERY, 32'h0, '0, '0);
        send_request(CMD_MARK, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_LIST_DUE, '0, '0, 32'h0);
        send_request(CMD_LIST_EXP, '0, '0, 32'hFFFF_FFFF);
        send_request(CMD_SPARE_6, '1, '1, '1);
        send_request(CMD_SPARE_7, '0, '0, '0);
        // tracks, duplicate, sequences across the wrap
        send_request(CMD_TRACK, 32'hFFFF_FFFF, '0, 32'd0);
        send_request(CMD_TRACK, 32'hFFFF_FFFF, '0, 32'd5);
        send_request(CMD_TRACK, 32'h0, '0, 32'hFFFF_FFFF);
        send_request(CMD_TRACK, 32'd5, '0, 32'd100);
        send_request(CMD_TRACK, 32'h8000_0004, '0, 32'd100);
        send_request(CMD_QUERY, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_MARK, 32'h0, '0, 32'd300);
        // timeout boundary and wrapped age
        send_request(CMD_LIST_DUE, '0, '0, 32'd199);
        send_request(CMD_LIST_DUE, '0, '0, 32'd200);
        send_request(CMD_LIST_EXP, '0, '0, 32'd200);
        // mask bit 1, exact ack, window edge, newer-than-ack, plain ack
        send_request(CMD_ACK, 32'd1, 32'h0000_0002, '0);
        send_request(CMD_ACK, 32'h8000_0004, 32'h0, '0);
        send_request(CMD_ACK, 32'd37, 32'h8000_0000, '0);
        send_request(CMD_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_request(CMD_ACK, 32'h0, 32'h0, '0);
        wait_idle();

        run_phase(32'd150, 8'd3, $urandom, 35, 0);
        run_phase(32'd1, 8'd0, 32'hFFFF_FFF0, 60, 400);
        run_phase(32'hFFFF_FFFF, 8'd255, 32'h7FFF_FFF0, 35, 0);
        run_phase(CFG_W'($urandom_range(1, 400)), RETRY_W'($urandom_range(0, 8)),
                  $urandom, 60, 0);
        run_phase(32'd50, 8'd2, 32'h0, 40, 0);

        $display("Run covered %0d requests and %0d results over %0d register settings,",
                 sb.requests, sb.results, register_sets);
        $display("with wrapped sequences and times, timeout edges and a long output hold.");
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
